FILE: hdl/rti_pkg.sv
package rti_pkg;

    // Coordinate format.
    localparam int CW    = 32;
    localparam int FB    = 16;
    localparam int TOL_W = 16;
    localparam int NV    = 9;
    localparam int IN_W  = NV * CW;

    // Exact intermediate widths: edges, cross products, dot products.
    localparam int EW    = CW + 1;
    localparam int XW    = 2 * EW + 1;
    localparam int SPLIT = XW - EW;
    localparam int PLW   = EW + SPLIT + 1;
    localparam int PHW   = 2 * EW;
    localparam int PW    = EW + XW;
    localparam int DW    = PW + 2;

    // Quotient and result widths.
    localparam int TQ    = 31;
    localparam int UQ    = 18;
    localparam int RW    = DW + FB + TQ;
    localparam int TW    = 31;
    localparam int BW    = 19;
    localparam int OUT_W = ((1 + TW + 2 * BW + 7) / 8) * 8;

    typedef struct packed {
        logic miss;
        logic neg_u;
        logic neg_v;
        logic sat_t;
    } t_div_ctl;

    typedef struct packed {
        logic [DW-1:0] den;
        logic [RW-1:0] rem_t;
        logic [RW-1:0] rem_u;
        logic [RW-1:0] rem_v;
        logic [TQ-1:0] q_t;
        logic [UQ-1:0] q_u;
        logic [UQ-1:0] q_v;
        t_div_ctl      ctl;
    } t_div_bus;

endpackage

FILE: hdl/rti_div.sv
module rti_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  rti_pkg::t_div_bus i_bus,
    output logic              o_vld,
    output rti_pkg::t_div_bus o_bus
);
    import rti_pkg::*;

    // One quotient bit per stage, most significant first. The u and v
    // quotients only occupy the last UQ stages.
    logic [TQ-1:0] r_vld;
    t_div_bus      r_stage [TQ];

    genvar s;
    generate
        for (s = 0; s < TQ; s++) begin : g_stage
            localparam int K = TQ - 1 - s;
            t_div_bus      w_prev;
            t_div_bus      w_next;
            logic [RW-1:0] w_dsh;
            logic [RW-1:0] w_rem_u;
            logic [RW-1:0] w_rem_v;
            logic [UQ-1:0] w_qu;
            logic [UQ-1:0] w_qv;

            if (s == 0) begin : g_first
                assign w_prev = i_bus;
            end else begin : g_rest
                assign w_prev = r_stage[s-1];
            end

            assign w_dsh = RW'(w_prev.den) << K;

            if (K < UQ) begin : g_uv
                always_comb begin
                    w_rem_u = w_prev.rem_u;
                    w_qu    = w_prev.q_u;
                    w_rem_v = w_prev.rem_v;
                    w_qv    = w_prev.q_v;
                    if (w_prev.rem_u >= w_dsh) begin
                        w_rem_u = w_prev.rem_u - w_dsh;
                        w_qu[K] = 1'b1;
                    end
                    if (w_prev.rem_v >= w_dsh) begin
                        w_rem_v = w_prev.rem_v - w_dsh;
                        w_qv[K] = 1'b1;
                    end
                end
            end else begin : g_pass
                assign w_rem_u = w_prev.rem_u;
                assign w_qu    = w_prev.q_u;
                assign w_rem_v = w_prev.rem_v;
                assign w_qv    = w_prev.q_v;
            end

            always_comb begin
                w_next       = w_prev;
                w_next.rem_u = w_rem_u;
                w_next.q_u   = w_qu;
                w_next.rem_v = w_rem_v;
                w_next.q_v   = w_qv;
                if (w_prev.rem_t >= w_dsh) begin
                    w_next.rem_t = w_prev.rem_t - w_dsh;
                    w_next.q_t[K] = 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else if (i_en) begin
                    r_vld[s] <= (s == 0) ? i_vld : r_vld[(s == 0) ? 0 : s-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_stage[s] <= w_next;
                end
            end
        end
    endgenerate

    assign o_vld = r_vld[TQ-1];
    assign o_bus = r_stage[TQ-1];

endmodule

FILE: hdl/ray_triangle_intersect.sv
// Moller-Trumbore ray/triangle test in signed Q16.16. The ray (origin,
// direction) and the tolerance are written through the configuration port
// while the block is idle; triangles then stream in as nine coordinates per
// word and one result word comes out per triangle, in order. The pipeline
// takes one triangle every cycle, and each triangle passes through seven stages
// of edge, cross and dot product arithmetic (products split into partial
// products of about 33 by 35 bits), 31 stages of a restoring divider that
// forms one quotient bit per stage for t and for u and v together, and the
// output register. When the output word is not taken, the whole pipeline
// holds. On a miss the word carries hit = 0 and zeros; a distance beyond
// the 31-bit range saturates.
module ray_triangle_intersect (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_idx,
    input  logic [rti_pkg::CW-1:0]      i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // vert_a_x, vert_a_y, vert_a_z, vert_b_x, ..., vert_c_z, 32 bits each
    input  logic [rti_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // hit, distance_param[30:0], bary_u[18:0], bary_v[18:0], two zero bits
    output logic [rti_pkg::OUT_W-1:0]   m_axis_tdata
);
    import rti_pkg::*;

    typedef enum logic [2:0] {
        REG_ORG_X,
        REG_ORG_Y,
        REG_ORG_Z,
        REG_DIR_X,
        REG_DIR_Y,
        REG_DIR_Z,
        REG_TOL
    } t_reg_idx;

    localparam logic [BW+1:0] ONE_FIX = (BW+2)'(1) << FB;

    // Configuration registers.
    logic signed [CW-1:0] r_org [3];
    logic signed [CW-1:0] r_dir [3];
    logic [TOL_W-1:0]     r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_dir[0] <= '0;
            r_dir[1] <= '0;
            r_dir[2] <= CW'(1) << FB;
            r_tol    <= TOL_W'(1);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ORG_X: r_org[0] <= i_cfg_data;
                REG_ORG_Y: r_org[1] <= i_cfg_data;
                REG_ORG_Z: r_org[2] <= i_cfg_data;
                REG_DIR_X: r_dir[0] <= i_cfg_data;
                REG_DIR_Y: r_dir[1] <= i_cfg_data;
                REG_DIR_Z: r_dir[2] <= i_cfg_data;
                REG_TOL:   r_tol    <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Whole-pipeline advance.
    logic r_out_vld;
    logic w_en;
    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    logic signed [CW-1:0] w_vert [NV];
    always_comb begin
        for (int i = 0; i < NV; i++) begin
            w_vert[i] = s_axis_tdata[i*CW +: CW];
        end
    end

    // Stage 1: edges and origin offset.
    logic                 r1_vld;
    logic signed [EW-1:0] r1_e1 [3];
    logic signed [EW-1:0] r1_e2 [3];
    logic signed [EW-1:0] r1_tv [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r1_e1[j] <= EW'(w_vert[3+j]) - EW'(w_vert[j]);
                r1_e2[j] <= EW'(w_vert[6+j]) - EW'(w_vert[j]);
                r1_tv[j] <= EW'(r_org[j]) - EW'(w_vert[j]);
            end
        end
    end

    // Stages 2 and 3: cross products pvec = dir x e2, qvec = tv x e1.
    logic                  r2_vld;
    logic signed [PHW-1:0] r2_pp [3][2];
    logic signed [PHW-1:0] r2_qp [3][2];
    logic signed [EW-1:0]  r2_e1 [3];
    logic signed [EW-1:0]  r2_e2 [3];
    logic signed [EW-1:0]  r2_tv [3];
    logic                  r3_vld;
    logic signed [XW-1:0]  r3_pv [3];
    logic signed [XW-1:0]  r3_qv [3];
    logic signed [EW-1:0]  r3_e1 [3];
    logic signed [EW-1:0]  r3_e2 [3];
    logic signed [EW-1:0]  r3_tv [3];

    genvar j;
    generate
        for (j = 0; j < 3; j++) begin : g_cross
            localparam int J1 = (j + 1) % 3;
            localparam int J2 = (j + 2) % 3;
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r2_pp[j][0] <= EW'(r_dir[J1]) * r1_e2[J2];
                    r2_pp[j][1] <= EW'(r_dir[J2]) * r1_e2[J1];
                    r2_qp[j][0] <= r1_tv[J1] * r1_e1[J2];
                    r2_qp[j][1] <= r1_tv[J2] * r1_e1[J1];
                    r2_e1[j]    <= r1_e1[j];
                    r2_e2[j]    <= r1_e2[j];
                    r2_tv[j]    <= r1_tv[j];
                    r3_pv[j]    <= XW'(r2_pp[j][0]) - XW'(r2_pp[j][1]);
                    r3_qv[j]    <= XW'(r2_qp[j][0]) - XW'(r2_qp[j][1]);
                    r3_e1[j]    <= r2_e1[j];
                    r3_e2[j]    <= r2_e2[j];
                    r3_tv[j]    <= r2_tv[j];
                end
            end
        end
    endgenerate

    // Stages 4 to 6: the four dot products det, u, v and t numerators.
    // Each wide factor is split so that no multiplier exceeds 33 by 35 bits.
    logic signed [EW-1:0]  w_a [4][3];
    logic signed [XW-1:0]  w_b [4][3];
    logic                  r4_vld;
    logic signed [PLW-1:0] r4_lo [4][3];
    logic signed [PHW-1:0] r4_hi [4][3];
    logic                  r5_vld;
    logic signed [PW-1:0]  r5_prod [4][3];
    logic                  r6_vld;
    logic signed [DW-1:0]  r6_sum [4];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_a[0][k] = r3_e1[k];
            w_b[0][k] = r3_pv[k];
            w_a[1][k] = r3_tv[k];
            w_b[1][k] = r3_pv[k];
            w_a[2][k] = EW'(r_dir[k]);
            w_b[2][k] = r3_qv[k];
            w_a[3][k] = r3_e2[k];
            w_b[3][k] = r3_qv[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int d = 0; d < 4; d++) begin
                for (int k = 0; k < 3; k++) begin
                    r4_lo[d][k]   <= w_a[d][k] * $signed({1'b0, w_b[d][k][SPLIT-1:0]});
                    r4_hi[d][k]   <= w_a[d][k] * $signed(w_b[d][k][XW-1:SPLIT]);
                    r5_prod[d][k] <= (PW'(r4_hi[d][k]) <<< SPLIT) + PW'(r4_lo[d][k]);
                end
                r6_sum[d] <= DW'(r5_prod[d][0]) + DW'(r5_prod[d][1]) + DW'(r5_prod[d][2]);
            end
        end
    end

    // Stage 7: magnitudes, miss tests and divider setup.
    logic [DW-1:0] w_mag [4];
    logic [DW-1:0] w_den;
    logic [RW-1:0] w_num [4];
    logic [RW-1:0] w_den_u;
    logic [RW-1:0] w_den_t;
    logic          w_par;
    logic          w_tneg;
    t_div_bus      w_bus;
    logic          r7_vld;
    t_div_bus      r7_bus;

    always_comb begin
        for (int d = 0; d < 4; d++) begin
            w_mag[d] = r6_sum[d][DW-1] ? DW'(-r6_sum[d]) : DW'(r6_sum[d]);
            w_num[d] = RW'(w_mag[d]) << FB;
        end
        w_den   = w_mag[0];
        w_den_u = RW'(w_den) << UQ;
        w_den_t = RW'(w_den) << TQ;
        // Too close to parallel, or exactly degenerate.
        w_par   = (w_den == '0) || (w_den < (DW'(r_tol) << (2 * FB)));
        w_tneg  = (r6_sum[3] != '0) && (r6_sum[3][DW-1] != r6_sum[0][DW-1]);

        w_bus.den       = w_den;
        w_bus.rem_u     = w_num[1];
        w_bus.rem_v     = w_num[2];
        w_bus.rem_t     = w_num[3];
        w_bus.q_t       = '0;
        w_bus.q_u       = '0;
        w_bus.q_v       = '0;
        w_bus.ctl.neg_u = r6_sum[1][DW-1] != r6_sum[0][DW-1];
        w_bus.ctl.neg_v = r6_sum[2][DW-1] != r6_sum[0][DW-1];
        w_bus.ctl.sat_t = w_num[3] >= w_den_t;
        // A u or v quotient of 2^UQ or more lies outside the band anyway.
        w_bus.ctl.miss  = w_par || w_tneg || (w_num[1] >= w_den_u) ||
                          (w_num[2] >= w_den_u);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_bus <= w_bus;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= s_axis_tvalid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
        end
    end

    logic     w_div_vld;
    t_div_bus w_div_bus;

    rti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r7_vld),
        .i_bus   (r7_bus),
        .o_vld   (w_div_vld),
        .o_bus   (w_div_bus)
    );

    // Output stage: signs, barycentric band tests, saturation.
    logic signed [BW-1:0]   w_u;
    logic signed [BW-1:0]   w_v;
    logic signed [BW+1:0]   w_eps;
    logic signed [BW+1:0]   w_hi;
    logic signed [BW+1:0]   w_uv;
    logic                   w_hit;
    logic                   r_hit;
    logic [TW-1:0]          r_t;
    logic signed [BW-1:0]   r_u;
    logic signed [BW-1:0]   r_v;

    always_comb begin
        w_u   = w_div_bus.ctl.neg_u ? -BW'(w_div_bus.q_u) : BW'(w_div_bus.q_u);
        w_v   = w_div_bus.ctl.neg_v ? -BW'(w_div_bus.q_v) : BW'(w_div_bus.q_v);
        w_eps = $signed((BW+2)'(r_tol));
        w_hi  = $signed(ONE_FIX) + w_eps;
        w_uv  = (BW+2)'(w_u) + (BW+2)'(w_v);
        w_hit = !w_div_bus.ctl.miss &&
                !((BW+2)'(w_u) < -w_eps) && !((BW+2)'(w_u) > w_hi) &&
                !((BW+2)'(w_v) < -w_eps) && !(w_uv > w_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit <= w_hit;
            r_t   <= !w_hit ? '0 : (w_div_bus.ctl.sat_t ? '1 : w_div_bus.q_t);
            r_u   <= w_hit ? w_u : '0;
            r_v   <= w_hit ? w_v : '0;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {(OUT_W - 1 - TW - 2 * BW)'(0), r_v, r_u, r_t, r_hit};

endmodule

FILE: hdl/rti_checker.sv
module rti_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [rti_pkg::OUT_W-1:0]   m_axis_tdata
);
    import rti_pkg::*;

    // The input side advances exactly when the output word can move.
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output side");

    // A miss word carries zeros in every field.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[OUT_W-1:1] == '0))
        else $error("miss word with nonzero fields");

    // A hit lies within the widest band the tolerance allows.
    a_hit_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |->
        ($signed(m_axis_tdata[TW+BW:TW+1]) >= -65535 &&
         $signed(m_axis_tdata[TW+BW:TW+1]) <= 131071 &&
         $signed(m_axis_tdata[TW+2*BW:TW+BW+1]) >= -65535))
        else $error("hit with barycentric value out of band");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output word changed");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: bench/tb_ray_triangle_intersect.sv
`timescale 1ns / 1ps

module tb_ray_triangle_intersect;
    import rti_pkg::*;

    localparam int REG_ORG_X = 0;
    localparam int REG_ORG_Y = 1;
    localparam int REG_ORG_Z = 2;
    localparam int REG_DIR_X = 3;
    localparam int REG_DIR_Y = 4;
    localparam int REG_DIR_Z = 5;
    localparam int REG_TOL   = 6;
    localparam int NUM_REGS  = 7;
    localparam int ONE       = 65536;
    localparam int DRAIN_CYCLES = 60;
    localparam int IDLE_LIMIT   = 4000;
    localparam int LONG_HOLD    = 400;

    typedef logic signed [255:0] wide_t;
    typedef logic [IN_W-1:0] tri_word_t;
    typedef logic [69:0] hit_word_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [2:0]        i_cfg_idx = '0;
    logic [CW-1:0]     i_cfg_data = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    tri_word_t         s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;

    ray_triangle_intersect dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Ray registers as the block should hold them.
    logic signed [31:0] ray_org [3];
    logic signed [31:0] ray_dir [3];
    logic [15:0]        ray_tol;

    tri_word_t pending_tris[$];
    hit_word_t expected_hits[$];
    int errors = 0;
    int n_hits = 0;
    int n_misses = 0;
    int n_sat = 0;
    int stall_pct = 20;
    int gap_max = 5;
    bit hold_req = 0;
    bit hold_seen = 0;
    int hold_left = 0;
    int burst_left = 0;
    int gap_left = 0;
    int idle_cycles = 0;

    function automatic hit_word_t intersect_triangle(tri_word_t w);
        wide_t ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z;
        wide_t dx, dy, dz, px, py, pz, tx, ty, tz, qx, qy, qz;
        wide_t det, eps, big, u, v, tn, t;
        logic [30:0] t_sat;
        ax = wide_t'($signed(w[0 +: 32]));
        ay = wide_t'($signed(w[32 +: 32]));
        az = wide_t'($signed(w[64 +: 32]));
        e1x = wide_t'($signed(w[96 +: 32])) - ax;
        e1y = wide_t'($signed(w[128 +: 32])) - ay;
        e1z = wide_t'($signed(w[160 +: 32])) - az;
        e2x = wide_t'($signed(w[192 +: 32])) - ax;
        e2y = wide_t'($signed(w[224 +: 32])) - ay;
        e2z = wide_t'($signed(w[256 +: 32])) - az;
        dx = wide_t'(ray_dir[0]);
        dy = wide_t'(ray_dir[1]);
        dz = wide_t'(ray_dir[2]);
        px = dy * e2z - dz * e2y;
        py = dz * e2x - dx * e2z;
        pz = dx * e2y - dy * e2x;
        det = e1x * px + e1y * py + e1z * pz;
        eps = ray_tol;
        big = eps <<< 32;
        if (det == 0 || (det > -big && det < big))
            return '0;
        tx = wide_t'(ray_org[0]) - ax;
        ty = wide_t'(ray_org[1]) - ay;
        tz = wide_t'(ray_org[2]) - az;
        u = ((tx * px + ty * py + tz * pz) <<< 16) / det;
        if (u < -eps || u > ONE + eps)
            return '0;
        qx = ty * e1z - tz * e1y;
        qy = tz * e1x - tx * e1z;
        qz = tx * e1y - ty * e1x;
        v = ((dx * qx + dy * qy + dz * qz) <<< 16) / det;
        if (v < -eps || u + v > ONE + eps)
            return '0;
        tn = e2x * qx + e2y * qy + e2z * qz;
        // A negative exact distance misses even when it truncates to zero.
        if (tn != 0 && (tn < 0) != (det < 0))
            return '0;
        t = (tn <<< 16) / det;
        t_sat = (t > wide_t'(2147483647)) ? 31'h7FFFFFFF : t[30:0];
        return {v[18:0], u[18:0], t_sat, 1'b1};
    endfunction

    function automatic tri_word_t pack_tri(int c[9]);
        tri_word_t w;
        for (int i = 0; i < 9; i++)
            w[32*i +: 32] = c[i];
        return w;
    endfunction

    function automatic int rand_span(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Triangle around a point on the ray at parameter k (Q16.16), possibly behind it.
    function automatic tri_word_t aimed_tri(int k, int spread);
        int c[9];
        longint p;
        for (int j = 0; j < 3; j++) begin
            p = longint'(ray_org[j]) + ((longint'(ray_dir[j]) * k) >>> 16);
            for (int i = 0; i < 3; i++)
                c[3*i + j] = int'(p) + rand_span(spread);
        end
        // Sometimes make it degenerate or exactly shared-vertex.
        case ($urandom_range(19))
            0: for (int j = 0; j < 3; j++) c[6 + j] = c[3 + j];
            1: for (int j = 0; j < 3; j++) c[3 + j] = c[j];
            default: ;
        endcase
        return pack_tri(c);
    endfunction

    function automatic tri_word_t noise_tri();
        int c[9];
        for (int i = 0; i < 9; i++)
            c[i] = $urandom;
        return pack_tri(c);
    endfunction

    task automatic queue_random(int count, int spread, int kmax);
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 70)
                pending_tris.push_back(aimed_tri($urandom_range(kmax), spread));
            else if (sel < 82)
                pending_tris.push_back(aimed_tri(-int'($urandom_range(kmax)), spread));
            else
                pending_tris.push_back(noise_tri());
        end
    endtask

    task automatic wait_drained();
        while (pending_tris.size() != 0 || expected_hits.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
    endtask

    task automatic write_ray(int ox, int oy, int oz, int dx, int dy, int dz, int tol);
        int vals[NUM_REGS];
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        vals[REG_ORG_X] = ox;
        vals[REG_ORG_Y] = oy;
        vals[REG_ORG_Z] = oz;
        vals[REG_DIR_X] = dx;
        vals[REG_DIR_Y] = dy;
        vals[REG_DIR_Z] = dz;
        vals[REG_TOL]   = tol;
        for (int r = 0; r < NUM_REGS; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= r[2:0];
            i_cfg_data <= (r == REG_TOL) ? (vals[r] & 32'hFFFF) : vals[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        ray_org[0] = ox;
        ray_org[1] = oy;
        ray_org[2] = oz;
        ray_dir[0] = dx;
        ray_dir[1] = dy;
        ray_dir[2] = dz;
        ray_tol    = tol[15:0];
    endtask

    task automatic add_tri(int ax, int ay, int az, int bx, int by, int bz,
                           int cx, int cy, int cz);
        int c[9];
        c = '{ax, ay, az, bx, by, bz, cx, cy, cz};
        pending_tris.push_back(pack_tri(c));
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_hits.push_back(intersect_triangle(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_tris.size() != 0) begin
                    s_axis_tdata  <= pending_tris.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 40);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = $urandom_range(gap_max);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold requested by the stimulus.
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        hit_word_t exp_w;
        hit_word_t act_w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            act_w = m_axis_tdata[69:0];
            if (expected_hits.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual %h", $time, act_w);
            end else begin
                exp_w = expected_hits.pop_front();
                if (exp_w[0]) n_hits++; else n_misses++;
                if (exp_w[31:1] == 31'h7FFFFFFF) n_sat++;
                if (act_w[0] !== exp_w[0]) begin
                    errors++;
                    $display("%0t: hit expected %b actual %b", $time, exp_w[0], act_w[0]);
                end
                if (act_w[31:1] !== exp_w[31:1]) begin
                    errors++;
                    $display("%0t: distance_param expected %h actual %h",
                             $time, exp_w[31:1], act_w[31:1]);
                end
                if (act_w[50:32] !== exp_w[50:32]) begin
                    errors++;
                    $display("%0t: bary_u expected %h actual %h",
                             $time, exp_w[50:32], act_w[50:32]);
                end
                if (act_w[69:51] !== exp_w[69:51]) begin
                    errors++;
                    $display("%0t: bary_v expected %h actual %h",
                             $time, exp_w[69:51], act_w[69:51]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we
                || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_ray_triangle_intersect: errors");
            $finish;
        end
    end

    initial begin
        ray_org = '{0, 0, 0};
        ray_dir = '{0, 0, ONE};
        ray_tol = 16'd1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset ray: origin at zero looking along +z, tolerance one LSB.
        add_tri(-ONE, -ONE, 5*ONE, 3*ONE, -ONE, 5*ONE, -ONE, 3*ONE, 5*ONE);
        add_tri(-ONE, -ONE, -5*ONE, 3*ONE, -ONE, -5*ONE, -ONE, 3*ONE, -5*ONE);
        add_tri(-ONE, -ONE, -1, 3*ONE, -ONE, -1, -ONE, 3*ONE, -1);
        add_tri(-ONE, -ONE, 0, 3*ONE, -ONE, 0, -ONE, 3*ONE, 0);
        add_tri(-ONE, 0, ONE, ONE, 0, ONE, 0, 0, 3*ONE);
        add_tri(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
        add_tri(ONE, -ONE, 2*ONE, 3*ONE, -ONE, 2*ONE, ONE, ONE, 2*ONE);
        add_tri(-3*ONE, -ONE, 2*ONE, -ONE, -ONE, 2*ONE, -3*ONE, ONE, 2*ONE);
        add_tri(-ONE, ONE, 2*ONE, ONE, ONE, 2*ONE, -ONE, 3*ONE, 2*ONE);
        add_tri(-ONE, -3*ONE, 2*ONE, ONE, -3*ONE, 2*ONE, -ONE, -ONE, 2*ONE);
        add_tri(-2*ONE, 0, 4*ONE, 0, -2*ONE, 4*ONE, 2*ONE, 2*ONE, 4*ONE);
        add_tri(0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE);
        add_tri(-ONE, -ONE, ONE, ONE, -ONE, ONE, -ONE, ONE, ONE);
        add_tri(-ONE, -ONE, ONE, -ONE, ONE, ONE, ONE, -ONE, ONE);
        add_tri(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
        add_tri(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        add_tri(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
        add_tri(-1, -1, 0, -1, -1, 0, -1, -1, 0);
        queue_random(350, 1 << 20, 1 << 22);
        wait_drained();

        // Random ray; the sender pauses halfway until all results are back.
        write_ray(rand_span(1 << 24), rand_span(1 << 24), rand_span(1 << 24),
                  rand_span(1 << 18), rand_span(1 << 18), rand_span(1 << 18),
                  $urandom_range(16'hFFFF));
        queue_random(130, 1 << 20, 1 << 22);
        wait_drained();
        gap_max = 0;
        stall_pct = 0;
        queue_random(130, 1 << 20, 1 << 22);

        // Zero tolerance, heavy receiver stalls and one long hold.
        write_ray(rand_span(1 << 20), rand_span(1 << 20), rand_span(1 << 20),
                  rand_span(1 << 17), rand_span(1 << 17), ONE + rand_span(1 << 16), 0);
        stall_pct = 60;
        gap_max = 3;
        queue_random(260, 1 << 19, 1 << 21);
        repeat (20) @(posedge i_clk);
        hold_req = !hold_req;

        // Largest tolerance.
        write_ray(rand_span(1 << 22), rand_span(1 << 22), rand_span(1 << 22),
                  rand_span(1 << 18), rand_span(1 << 18), rand_span(1 << 18), 16'hFFFF);
        stall_pct = 20;
        gap_max = 8;
        queue_random(260, 1 << 20, 1 << 22);

        // Tiny direction along +z: far triangles saturate the distance.
        write_ray(rand_span(1 << 20), rand_span(1 << 20), 0, 0, 0, 1, 0);
        queue_random(130, 1 << 20, 32'h7FFFFFFF);
        queue_random(130, 1 << 20, 1 << 10);

        // Register extremes.
        write_ray(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                  32'h80000000, 16'hFFFF);
        queue_random(120, 1 << 30, 1 << 16);
        write_ray(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                  32'h7FFFFFFF, 0);
        queue_random(120, 1 << 30, 1 << 16);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d hits (%0d saturated) and %0d misses over seven ray settings,",
                 n_hits, n_sat, n_misses);
        $display("with random bursts, receiver stalls and one long output hold.");
        if (errors == 0)
            $display("tb_ray_triangle_intersect: clean");
        else
            $display("tb_ray_triangle_intersect: errors");
        $finish;
    end

endmodule

FILE: ray_triangle_intersect.f
hdl/rti_pkg.sv
hdl/rti_div.sv
hdl/ray_triangle_intersect.sv
hdl/rti_checker.sv
bench/tb_ray_triangle_intersect.sv
